// ===== sv/pll_pkg.sv =====
// ----------------------------------------------------------------------------
// pll_pkg - shared types, codes and microcode for the pooled list engine
// Status and action codes, datapath op codes, jump conditions, the control
// word layout and the read-only microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

package pll_pkg;

   localparam int NODES_DEFAULT = 16;
   localparam int MAX_OUT       = 16;             // results per find, at most
   localparam int CNT_W         = $clog2(MAX_OUT);
   localparam int SLOT_W        = 4;
   localparam int NUM_W         = 32;
   localparam int GRADE_W       = 16;
   localparam int UPC_W         = 5;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BADPRED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // datapath operations, one per control word
   typedef enum logic [4:0] {
      OP_NOP,
      OP_CLEAR,
      OP_ACCEPT,
      OP_INS_RD_PRED,
      OP_INS_RD_FREE,
      OP_INS_CHECK,
      OP_INS_COMMIT,
      OP_INS_LINK,
      OP_DEL_RD,
      OP_DEL_CHECK,
      OP_RD_PTR,
      OP_DEL_UNLINK,
      OP_DEL_FREE,
      OP_EMIT,
      OP_FND_INIT,
      OP_W1_STEP,
      OP_FND_REWIND,
      OP_W2_STEP,
      OP_EMIT_STK
   } op_type;

   // jump conditions: taken goes to target, else fall through; dispatch jumps by action
   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_DISPATCH,
      C_CLR_MORE,
      C_BAD,
      C_HEAD_NIL,
      C_NEXT_LIVE,
      C_STK_MORE
   } cond_type;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_ONE = 5'd1;

   // microprogram addresses
   localparam upc_type U_CLR  = 5'd0;
   localparam upc_type U_IDLE = 5'd1;
   localparam upc_type U_INS0 = 5'd2;
   localparam upc_type U_INS1 = 5'd3;
   localparam upc_type U_INS2 = 5'd4;
   localparam upc_type U_INS3 = 5'd5;
   localparam upc_type U_INS4 = 5'd6;
   localparam upc_type U_DEL0 = 5'd7;
   localparam upc_type U_DEL1 = 5'd8;
   localparam upc_type U_DEL2 = 5'd9;
   localparam upc_type U_DEL3 = 5'd10;
   localparam upc_type U_DEL4 = 5'd11;
   localparam upc_type U_EMIT = 5'd12;
   localparam upc_type U_FND0 = 5'd13;
   localparam upc_type U_FND1 = 5'd14;
   localparam upc_type U_FND2 = 5'd15;
   localparam upc_type U_FND3 = 5'd16;
   localparam upc_type U_FND4 = 5'd17;
   localparam upc_type U_FND5 = 5'd18;
   localparam upc_type U_FND6 = 5'd19;
   localparam upc_type U_FND7 = 5'd20;
   localparam upc_type U_FND8 = 5'd21;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     wait_out;   // hold here until the result register is free
      upc_type  target;
   } ctl_word_type;

   typedef struct packed {
      logic out_free;
      logic head_nil;
      logic bad;
      logic next_live;
      logic stk_more;
      logic clr_more;
   } dp_flags_type;

   function automatic ctl_word_type ucode_rom(input upc_type addr);
      ctl_word_type w;
      case (addr)
         U_CLR:  w = '{OP_CLEAR,       C_CLR_MORE,  1'b0, U_CLR};
         U_IDLE: w = '{OP_ACCEPT,      C_DISPATCH,  1'b0, U_IDLE};
         // insert
         U_INS0: w = '{OP_INS_RD_PRED, C_NEXT,      1'b0, U_IDLE};
         U_INS1: w = '{OP_INS_RD_FREE, C_NEXT,      1'b0, U_IDLE};
         U_INS2: w = '{OP_INS_CHECK,   C_BAD,       1'b0, U_EMIT};
         U_INS3: w = '{OP_INS_COMMIT,  C_NEXT,      1'b0, U_IDLE};
         U_INS4: w = '{OP_INS_LINK,    C_ALWAYS,    1'b0, U_EMIT};
         // delete
         U_DEL0: w = '{OP_DEL_RD,      C_HEAD_NIL,  1'b0, U_EMIT};
         U_DEL1: w = '{OP_DEL_CHECK,   C_BAD,       1'b0, U_EMIT};
         U_DEL2: w = '{OP_RD_PTR,      C_NEXT,      1'b0, U_IDLE};
         U_DEL3: w = '{OP_DEL_UNLINK,  C_NEXT,      1'b0, U_IDLE};
         U_DEL4: w = '{OP_DEL_FREE,    C_NEXT,      1'b0, U_IDLE};
         // single result
         U_EMIT: w = '{OP_EMIT,        C_ALWAYS,    1'b1, U_IDLE};
         // find minimum: walk, rewind, walk and push, pop
         U_FND0: w = '{OP_FND_INIT,    C_HEAD_NIL,  1'b0, U_EMIT};
         U_FND1: w = '{OP_RD_PTR,      C_NEXT,      1'b0, U_IDLE};
         U_FND2: w = '{OP_W1_STEP,     C_NEXT_LIVE, 1'b0, U_FND1};
         U_FND3: w = '{OP_FND_REWIND,  C_NEXT,      1'b0, U_IDLE};
         U_FND4: w = '{OP_RD_PTR,      C_NEXT,      1'b0, U_IDLE};
         U_FND5: w = '{OP_W2_STEP,     C_NEXT_LIVE, 1'b0, U_FND4};
         U_FND6: w = '{OP_NOP,         C_NEXT,      1'b0, U_IDLE};
         U_FND7: w = '{OP_EMIT_STK,    C_STK_MORE,  1'b1, U_FND6};
         U_FND8: w = '{OP_NOP,         C_ALWAYS,    1'b0, U_IDLE};
         default: w = '{OP_NOP,        C_ALWAYS,    1'b0, U_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pll_ram.sv =====
// ----------------------------------------------------------------------------
// pll_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/pll_useq.sv =====
// ----------------------------------------------------------------------------
// pll_useq - microcode sequencer
// Step counter, control store lookup and conditional / dispatch jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_useq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_action,
   input  wire pll_pkg::dp_flags_type flags,
   output pll_pkg::ctl_word_type      ctl
);

   pll_pkg::upc_type upc_ff;
   pll_pkg::upc_type upc_in;
   logic             take;

   assign ctl = pll_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (ctl.cond)
         pll_pkg::C_NEXT:      take = 1'b0;
         pll_pkg::C_ALWAYS:    take = 1'b1;
         pll_pkg::C_CLR_MORE:  take = flags.clr_more;
         pll_pkg::C_BAD:       take = flags.bad;
         pll_pkg::C_HEAD_NIL:  take = flags.head_nil;
         pll_pkg::C_NEXT_LIVE: take = flags.next_live;
         pll_pkg::C_STK_MORE:  take = flags.stk_more;
         default:              take = 1'b0;
      endcase
   end

   always_comb begin
      if (ctl.wait_out && !flags.out_free) begin
         upc_in = upc_ff;
      end else if (ctl.cond == pll_pkg::C_DISPATCH) begin
         if (!req_valid) begin
            upc_in = upc_ff;
         end else begin
            case (pll_pkg::action_type'(req_action))
               pll_pkg::ACT_INSERT: upc_in = pll_pkg::U_INS0;
               pll_pkg::ACT_DELETE: upc_in = pll_pkg::U_DEL0;
               pll_pkg::ACT_FIND:   upc_in = pll_pkg::U_FND0;
               default:             upc_in = pll_pkg::U_EMIT;
            endcase
         end
      end else if (take) begin
         upc_in = ctl.target;
      end else begin
         upc_in = upc_ff + pll_pkg::UPC_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= pll_pkg::U_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pll_datapath.sv =====
// ----------------------------------------------------------------------------
// pll_datapath - node pool, free chain and result register
// Link, number, grade and match stack RAMs with the pointer, minimum and
// stack registers, driven one op per cycle by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_datapath #(
   parameter int NODES = pll_pkg::NODES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pll_pkg::ctl_word_type         ctl,
   output pll_pkg::dp_flags_type              flags,
   input  wire logic                          req_valid,
   input  wire logic                          req_at_head,
   input  wire logic [pll_pkg::SLOT_W-1:0]    req_pred_index,
   input  wire logic [pll_pkg::NUM_W-1:0]     req_reg_number,
   input  wire logic [pll_pkg::GRADE_W-1:0]   req_grade,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [pll_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic [pll_pkg::NUM_W-1:0]          rsp_found_number,
   output logic [pll_pkg::GRADE_W-1:0]        rsp_min_grade,
   output logic                               rsp_list_empty,
   output logic                               rsp_list_full,
   output logic                               rsp_last
);

   localparam int AW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1);
   localparam logic [LW-1:0] NIL = LW'(NODES);

   // control registers
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] free_ff, free_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // request and working registers
   logic                        at_head_ff, at_head_in;
   logic [pll_pkg::SLOT_W-1:0]  pred_ff, pred_in;
   logic [pll_pkg::NUM_W-1:0]   number_ff, number_in;
   logic [pll_pkg::GRADE_W-1:0] grade_ff, grade_in;
   logic [LW-1:0]               ptr_ff, ptr_in;
   logic [LW-1:0]               nxt_ff, nxt_in;
   logic [LW:0]                 predw_ff, predw_in;
   logic [pll_pkg::GRADE_W-1:0] best_ff, best_in;
   logic [LW-1:0]               sp_ff, sp_in;
   logic [pll_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   pll_pkg::status_type         stat_ff, stat_in;
   logic [pll_pkg::SLOT_W-1:0]  slot_ff, slot_in;

   // result register payload
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [pll_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [pll_pkg::NUM_W-1:0]   rsp_number_ff, rsp_number_in;
   logic [pll_pkg::GRADE_W-1:0] rsp_grade_ff, rsp_grade_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic                        rsp_full_ff, rsp_full_in;
   logic                        rsp_last_ff, rsp_last_in;

   // memory ports
   logic [LW:0]                 link_rdata, link_wdata;
   logic [pll_pkg::NUM_W-1:0]   num_rdata, stk_rdata;
   logic [pll_pkg::GRADE_W-1:0] grade_rdata;
   logic [AW-1:0]               node_addr, link_waddr;
   logic                        link_we, node_we, stk_we;
   logic [LW-1:0]               sp_m1;

   // decoded views
   logic          r_in;
   logic [LW-1:0] r_link;
   logic [31:0]   pred_wide, ptr_wide;
   logic [AW-1:0] pred_addr, ptr_addr;
   logic          pred_ok, head_nil, free_nil, out_free;
   logic          ins_bad, del_bad, stk_more;

   assign r_in      = link_rdata[LW];
   assign r_link    = link_rdata[LW-1:0];
   assign pred_wide = 32'(pred_ff);
   assign ptr_wide  = 32'(ptr_ff);
   assign pred_addr = pred_wide[AW-1:0];
   assign ptr_addr  = ptr_ff[AW-1:0];
   assign pred_ok   = pred_wide < 32'(NODES);
   assign head_nil  = head_ff == NIL;
   assign free_nil  = free_ff == NIL;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sp_m1     = sp_ff - LW'(1);

   assign ins_bad  = free_nil || (!at_head_ff && (!pred_ok || !predw_ff[LW]));
   assign del_bad  = !at_head_ff && (!pred_ok || !r_in || r_link == NIL);
   assign stk_more = (sp_ff != LW'(1)) && (cnt_ff != pll_pkg::CNT_W'(pll_pkg::MAX_OUT - 1));

   always_comb begin
      flags.out_free  = out_free;
      flags.head_nil  = head_nil;
      flags.bad       = (ctl.op == pll_pkg::OP_INS_CHECK) ? ins_bad : del_bad;
      flags.next_live = r_link != NIL;
      flags.stk_more  = stk_more;
      flags.clr_more  = clr_ff != AW'(NODES - 1);
   end

   // node read address, shared by link, number and grade stores
   always_comb begin
      case (ctl.op)
         pll_pkg::OP_INS_RD_PRED: node_addr = pred_addr;
         pll_pkg::OP_INS_RD_FREE: node_addr = free_ff[AW-1:0];
         pll_pkg::OP_DEL_RD:      node_addr = at_head_ff ? head_ff[AW-1:0] : pred_addr;
         default:                 node_addr = ptr_addr;
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      free_in      = free_ff;
      clr_in       = clr_ff;
      at_head_in   = at_head_ff;
      pred_in      = pred_ff;
      number_in    = number_ff;
      grade_in     = grade_ff;
      ptr_in       = ptr_ff;
      nxt_in       = nxt_ff;
      predw_in     = predw_ff;
      best_in      = best_ff;
      sp_in        = sp_ff;
      cnt_in       = cnt_ff;
      stat_in      = stat_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_number_in = rsp_number_ff;
      rsp_grade_in  = rsp_grade_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_last_in   = rsp_last_ff;
      link_we      = 1'b0;
      link_waddr   = ptr_addr;
      link_wdata   = {1'b0, free_ff};
      node_we      = 1'b0;
      stk_we       = 1'b0;

      case (ctl.op)
         pll_pkg::OP_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = {1'b0, LW'(clr_ff) + LW'(1)};
            clr_in     = clr_ff + AW'(1);
         end
         pll_pkg::OP_ACCEPT: begin
            if (req_valid) begin
               at_head_in = req_at_head;
               pred_in    = req_pred_index;
               number_in  = req_reg_number;
               grade_in   = req_grade;
               stat_in    = pll_pkg::ST_OK;
               slot_in    = '0;
            end
         end
         pll_pkg::OP_INS_RD_FREE: begin
            predw_in = link_rdata;
         end
         pll_pkg::OP_INS_CHECK: begin
            ptr_in = free_ff;
            nxt_in = r_link;
            if (free_nil) begin
               stat_in = pll_pkg::ST_FULL;
            end else if (ins_bad) begin
               stat_in = pll_pkg::ST_BADPRED;
            end
         end
         pll_pkg::OP_INS_COMMIT: begin
            link_we    = 1'b1;
            link_waddr = ptr_addr;
            link_wdata = {1'b1, at_head_ff ? head_ff : predw_ff[LW-1:0]};
            node_we    = 1'b1;
            free_in    = nxt_ff;
            slot_in    = ptr_wide[pll_pkg::SLOT_W-1:0];
            if (at_head_ff) begin
               head_in = ptr_ff;
            end
         end
         pll_pkg::OP_INS_LINK: begin
            if (!at_head_ff) begin
               link_we    = 1'b1;
               link_waddr = pred_addr;
               link_wdata = {1'b1, ptr_ff};
            end
         end
         pll_pkg::OP_DEL_RD: begin
            if (head_nil) begin
               stat_in = pll_pkg::ST_EMPTY;
            end
         end
         pll_pkg::OP_DEL_CHECK: begin
            ptr_in = at_head_ff ? head_ff : r_link;
            if (del_bad) begin
               stat_in = pll_pkg::ST_BADPRED;
            end
         end
         pll_pkg::OP_DEL_UNLINK: begin
            if (at_head_ff) begin
               head_in = r_link;
            end else begin
               link_we    = 1'b1;
               link_waddr = pred_addr;
               link_wdata = {1'b1, r_link};
            end
         end
         pll_pkg::OP_DEL_FREE: begin
            link_we    = 1'b1;
            link_waddr = ptr_addr;
            link_wdata = {1'b0, free_ff};
            free_in    = ptr_ff;
            slot_in    = ptr_wide[pll_pkg::SLOT_W-1:0];
         end
         pll_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_slot_in   = slot_ff;
               rsp_number_in = '0;
               rsp_grade_in  = '0;
               rsp_empty_in  = head_nil;
               rsp_full_in   = free_nil;
               rsp_last_in   = 1'b1;
            end
         end
         pll_pkg::OP_FND_INIT: begin
            ptr_in  = head_ff;
            best_in = '1;
            sp_in   = '0;
            cnt_in  = '0;
            if (head_nil) begin
               stat_in = pll_pkg::ST_EMPTY;
            end
         end
         pll_pkg::OP_W1_STEP: begin
            if (grade_rdata < best_ff) begin
               best_in = grade_rdata;
            end
            ptr_in = r_link;
         end
         pll_pkg::OP_FND_REWIND: begin
            ptr_in = head_ff;
         end
         pll_pkg::OP_W2_STEP: begin
            if (grade_rdata == best_ff) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + LW'(1);
            end
            ptr_in = r_link;
         end
         pll_pkg::OP_EMIT_STK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pll_pkg::ST_OK;
               rsp_slot_in   = '0;
               rsp_number_in = stk_rdata;
               rsp_grade_in  = best_ff;
               rsp_empty_in  = head_nil;
               rsp_full_in   = free_nil;
               rsp_last_in   = !stk_more;
               sp_in         = sp_m1;
               cnt_in        = cnt_ff + pll_pkg::CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         free_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      at_head_ff    <= at_head_in;
      pred_ff       <= pred_in;
      number_ff     <= number_in;
      grade_ff      <= grade_in;
      ptr_ff        <= ptr_in;
      nxt_ff        <= nxt_in;
      predw_ff      <= predw_in;
      best_ff       <= best_in;
      sp_ff         <= sp_in;
      cnt_ff        <= cnt_in;
      stat_ff       <= stat_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_number_ff <= rsp_number_in;
      rsp_grade_ff  <= rsp_grade_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // {in-list bit, next link} per slot
   pll_ram #(.WIDTH(LW + 1), .DEPTH(NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (node_addr),
      .rd_data (link_rdata)
   );

   pll_ram #(.WIDTH(pll_pkg::NUM_W), .DEPTH(NODES)) u_num_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (ptr_addr),
      .wr_data (number_ff),
      .rd_addr (node_addr),
      .rd_data (num_rdata)
   );

   pll_ram #(.WIDTH(pll_pkg::GRADE_W), .DEPTH(NODES)) u_grade_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (ptr_addr),
      .wr_data (grade_ff),
      .rd_addr (node_addr),
      .rd_data (grade_rdata)
   );

   // match stack: pushed on the second walk, popped top first
   pll_ram #(.WIDTH(pll_pkg::NUM_W), .DEPTH(NODES)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (num_rdata),
      .rd_addr (sp_m1[AW-1:0]),
      .rd_data (stk_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_found_number = rsp_number_ff;
   assign rsp_min_grade    = rsp_grade_ff;
   assign rsp_list_empty   = rsp_empty_ff;
   assign rsp_list_full    = rsp_full_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/pooled_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// pooled_linked_list_engine - linked list in a node pool with a free chain
// Insert, delete and find-minimum over a singly linked list kept in a fixed
// pool of slots, run by a microcoded sequencer over a RAM-based datapath.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Carries
//  -------  ---  ------------------  ---------------------------------------
//  req_     in   req_valid/ready     action, at_head, pred_index, number,
//                                    grade (one transaction per command)
//  rsp_     out  rsp_valid/ready     status, slot, number, min grade, list
//                                    flags, last (1..16 transactions/command)
//
//  Flow: insert/delete run their routine and load one result (error exits
//  skip ahead to it); find walks the list twice, to get the minimum and then
//  to push its matches, and then pops the stack, one result per pop.
//  Reset: a clearing pass over every slot rebuilds the free chain in the
//  link RAM; req_ready stays low until it is done.
//  Stalls: rsp_ready low holds the result register and the sequencer's emit words.
// ----------------------------------------------------------------------------
`default_nettype none

module pooled_linked_list_engine #(
   parameter int NODES = pll_pkg::NODES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // command transactions
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_action,
   input  wire logic                        req_at_head,
   input  wire logic [pll_pkg::SLOT_W-1:0]  req_pred_index,
   input  wire logic [pll_pkg::NUM_W-1:0]   req_reg_number,
   input  wire logic [pll_pkg::GRADE_W-1:0] req_grade,
   // result transactions
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [pll_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [pll_pkg::NUM_W-1:0]        rsp_found_number,
   output logic [pll_pkg::GRADE_W-1:0]      rsp_min_grade,
   output logic                             rsp_list_empty,
   output logic                             rsp_list_full,
   output logic                             rsp_last
);

   pll_pkg::ctl_word_type ctl;
   pll_pkg::dp_flags_type flags;

   // A command is taken only while the microprogram sits at its idle word;
   // the dispatch jump leaves that word in the same cycle the transaction
   // is accepted.
   assign req_ready = (ctl.op == pll_pkg::OP_ACCEPT);

   // Sequencer: step counter plus control store. Each word names one
   // datapath op, a jump condition and a target; dispatch maps the
   // incoming action to the start of its routine.
   pll_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .flags      (flags),
      .ctl        (ctl)
   );

   // Datapath: link RAM holds {in-list, next} per slot, so the predecessor
   // check and its link come from one read. Numbers and grades share the
   // same read address. The match stack is a RAM indexed by its top.
   pll_datapath #(.NODES(NODES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .flags            (flags),
      .req_valid        (req_valid),
      .req_at_head      (req_at_head),
      .req_pred_index   (req_pred_index),
      .req_reg_number   (req_reg_number),
      .req_grade        (req_grade),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_found_number (rsp_found_number),
      .rsp_min_grade    (rsp_min_grade),
      .rsp_list_empty   (rsp_list_empty),
      .rsp_list_full    (rsp_list_full),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sv/pll_checker.sv =====
// ----------------------------------------------------------------------------
// pll_checker - port-level checks for the pooled list engine
// Watches the top level's ports over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_found_number,
   input wire logic        rsp_list_empty,
   input wire logic        rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_found_number) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // one command in flight
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   // only a find result stream has non-final results, all ok
   a_stream_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == pll_pkg::ST_OK)
      else $error("non-final result with error status");

   // empty status agrees with the list flag
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pll_pkg::ST_EMPTY) |-> rsp_list_empty)
      else $error("empty status with non-empty list");

endmodule

bind pooled_linked_list_engine pll_checker u_pll_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_found_number (rsp_found_number),
   .rsp_list_empty   (rsp_list_empty),
   .rsp_last         (rsp_last)
);

`default_nettype wire
